FILE: rtl/core/dis_pkg.sv
// ----------------------------------------------------------------------------
// DIS PDU parser package
// Shared types, constants and field width tables for the PDU field parser.
// ----------------------------------------------------------------------------
package dis_pkg;

    localparam int MaxPduBytes = 4096;
    localparam int OffsetW     = $clog2(MaxPduBytes + 1);

    localparam logic [6:0] EsFields   = 7'd71;
    localparam logic [6:0] FireFields = 7'd38;
    localparam logic [6:0] DetFields  = 7'd42;
    localparam logic [6:0] HdrFields  = 7'd7;

    localparam logic [6:0] TypeFieldIdx   = 7'd2;
    localparam logic [6:0] EsArtCountIdx  = 7'd11;
    localparam logic [6:0] DetArtCountIdx = 7'd40;
    localparam logic [2:0] ArtSubFields   = 3'd5;

    localparam logic [OffsetW-1:0] EsMinBytes   = OffsetW'(144);
    localparam logic [OffsetW-1:0] FireMinBytes = OffsetW'(96);
    localparam logic [OffsetW-1:0] DetMinBytes  = OffsetW'(104);

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_ES     = 2'd1,
        KIND_FIRE   = 2'd2,
        KIND_DET    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_SHORT       = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_ES_CODE   = 2'd0,
        REG_FIRE_CODE = 2'd1,
        REG_DET_CODE  = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
    } t_in_word;

    typedef struct packed {
        logic        has_field;
        logic [1:0]  pdu_kind;
        logic [6:0]  field_index;
        logic [7:0]  record_number;
        logic [3:0]  field_bytes;
        logic [63:0] field_value;
        logic [1:0]  status;
        logic        last;
    } t_out_word;

    function automatic logic [3:0] es_width(input logic [6:0] idx);
        logic [3:0] w;
        case (idx) inside
            [7'd0:7'd3]:   w = 4'd1;
            7'd4:          w = 4'd4;
            [7'd5:7'd9]:   w = 4'd2;
            [7'd10:7'd13]: w = 4'd1;
            7'd14:         w = 4'd2;
            [7'd15:7'd20]: w = 4'd1;
            7'd21:         w = 4'd2;
            [7'd22:7'd25]: w = 4'd1;
            [7'd26:7'd28]: w = 4'd4;
            [7'd29:7'd31]: w = 4'd8;
            [7'd32:7'd35]: w = 4'd4;
            [7'd36:7'd51]: w = 4'd1;
            [7'd52:7'd57]: w = 4'd4;
            [7'd58:7'd69]: w = 4'd1;
            7'd70:         w = 4'd4;
            default:       w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] fire_width(input logic [6:0] idx);
        logic [3:0] w;
        case (idx) inside
            [7'd0:7'd3]:   w = 4'd1;
            7'd4:          w = 4'd4;
            [7'd5:7'd18]:  w = 4'd2;
            7'd19:         w = 4'd4;
            [7'd20:7'd22]: w = 4'd8;
            [7'd23:7'd24]: w = 4'd1;
            7'd25:         w = 4'd2;
            [7'd26:7'd29]: w = 4'd1;
            [7'd30:7'd33]: w = 4'd2;
            [7'd34:7'd37]: w = 4'd4;
            default:       w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] det_width(input logic [6:0] idx);
        logic [3:0] w;
        case (idx) inside
            [7'd0:7'd3]:   w = 4'd1;
            7'd4:          w = 4'd4;
            [7'd5:7'd18]:  w = 4'd2;
            [7'd19:7'd21]: w = 4'd4;
            [7'd22:7'd24]: w = 4'd8;
            [7'd25:7'd26]: w = 4'd1;
            7'd27:         w = 4'd2;
            [7'd28:7'd31]: w = 4'd1;
            [7'd32:7'd35]: w = 4'd2;
            [7'd36:7'd38]: w = 4'd4;
            [7'd39:7'd40]: w = 4'd1;
            7'd41:         w = 4'd2;
            default:       w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] art_width(input logic [2:0] sub);
        logic [3:0] w;
        case (sub)
            3'd0:    w = 4'd1;
            3'd1:    w = 4'd1;
            3'd2:    w = 4'd2;
            3'd3:    w = 4'd4;
            3'd4:    w = 4'd8;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/dis_pdu_field_parser_unit.sv
// ----------------------------------------------------------------------------
// DIS PDU field parser unit
// Assembles the fixed fields and articulation records of Entity State, Fire
// and Detonation PDUs from a byte stream and reports frame status at close.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Direction
//  input     i_in_valid/o_in_ready/i_in       byte word in
//  output    o_out_valid/i_out_ready/o_out    field or close word out
//  config    i_cfg_we/i_cfg_index/i_cfg_data  type code writes
//
// One byte word is taken every cycle unless the output stalls; its result
// is in the output register on the next cycle. The output register is the
// only stage, so a word is accepted whenever that register is empty or is
// being read. Reset clears the frame state and loads default type codes.
// A stalled output holds its word and stops the input until it is taken.
module dis_pdu_field_parser_unit
    import dis_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]         r_es_code, r_fire_code, r_det_code;
    logic [OffsetW-1:0] r_offset, n_offset;
    logic [63:0]        r_acc, n_acc;
    t_kind              r_kind, n_kind;
    logic [7:0]         r_art_count, n_art_count;
    logic               r_unsup, n_unsup;
    logic [6:0]         r_field, n_field;
    logic [3:0]         r_fill, n_fill;
    logic [7:0]         r_rec, n_rec;
    logic [2:0]         r_sub, n_sub;
    logic               r_in_frame, n_in_frame;
    logic               r_out_valid;
    t_out_word          r_out, n_out;
    logic               n_emit;

    logic accept;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        logic [6:0]  nfix;
        logic [6:0]  idx;
        logic [7:0]  recno;
        logic [3:0]  width;
        logic [63:0] acc;
        logic        have;
        logic [OffsetW-1:0] need;

        n_offset    = r_offset;
        n_acc       = r_acc;
        n_kind      = r_kind;
        n_art_count = r_art_count;
        n_unsup     = r_unsup;
        n_field     = r_field;
        n_fill      = r_fill;
        n_rec       = r_rec;
        n_sub       = r_sub;
        n_in_frame  = r_in_frame;
        if (i_in.frame_start) begin
            n_offset    = '0;
            n_acc       = '0;
            n_kind      = KIND_HEADER;
            n_art_count = '0;
            n_unsup     = 1'b0;
            n_field     = '0;
            n_fill      = '0;
            n_rec       = '0;
            n_sub       = '0;
            n_in_frame  = 1'b1;
        end

        idx   = '0;
        recno = '0;
        width = '0;
        have  = 1'b0;
        acc   = '0;
        case (n_kind)
            KIND_ES:   nfix = EsFields;
            KIND_FIRE: nfix = FireFields;
            KIND_DET:  nfix = DetFields;
            default:   nfix = HdrFields;
        endcase

        if (n_in_frame && n_offset < OffsetW'(MaxPduBytes)) begin
            n_offset = n_offset + 1'b1;
            if (n_field < nfix) begin
                idx = n_field;
                case (n_kind)
                    KIND_FIRE: width = fire_width(n_field);
                    KIND_DET:  width = det_width(n_field);
                    default:   width = es_width(n_field);
                endcase
            end else if ((n_kind == KIND_ES || n_kind == KIND_DET)
                         && n_rec < n_art_count && n_sub < ArtSubFields) begin
                idx   = nfix + 7'(n_sub);
                recno = n_rec + 1'b1;
                width = art_width(n_sub);
            end
            if (width != 4'd0) begin
                acc    = {n_acc[55:0], i_in.data_byte};
                n_acc  = acc;
                n_fill = n_fill + 1'b1;
                if (n_fill >= width) begin
                    have   = 1'b1;
                    n_acc  = '0;
                    n_fill = '0;
                    if (recno == 8'd0) begin
                        if (idx == TypeFieldIdx) begin
                            if (i_in.data_byte == r_es_code) n_kind = KIND_ES;
                            else if (i_in.data_byte == r_fire_code) n_kind = KIND_FIRE;
                            else if (i_in.data_byte == r_det_code) n_kind = KIND_DET;
                            else n_unsup = 1'b1;
                        end
                        if ((n_kind == KIND_ES && idx == EsArtCountIdx)
                            || (n_kind == KIND_DET && idx == DetArtCountIdx)) begin
                            n_art_count = acc[7:0];
                        end
                        n_field = n_field + 1'b1;
                    end else begin
                        n_sub = n_sub + 1'b1;
                        if (n_sub >= ArtSubFields) begin
                            n_sub = '0;
                            n_rec = n_rec + 1'b1;
                        end
                    end
                end
            end
        end

        case (n_kind)
            KIND_ES:   need = EsMinBytes;
            KIND_FIRE: need = FireMinBytes;
            KIND_DET:  need = DetMinBytes;
            default:   need = '0;
        endcase

        n_out           = '0;
        n_out.pdu_kind  = n_kind;
        if (have) begin
            n_out.has_field     = 1'b1;
            n_out.field_index   = idx;
            n_out.record_number = recno;
            n_out.field_bytes   = width;
            n_out.field_value   = acc;
        end
        n_emit = n_in_frame && (have || i_in.frame_end);
        if (n_in_frame && i_in.frame_end) begin
            if (n_unsup) n_out.status = ST_UNSUPPORTED;
            else if (n_kind == KIND_HEADER || n_offset < need) n_out.status = ST_SHORT;
            else n_out.status = ST_OK;
            n_out.last = 1'b1;
            n_in_frame = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_es_code   <= 8'd1;
            r_fire_code <= 8'd2;
            r_det_code  <= 8'd3;
            r_offset    <= '0;
            r_acc       <= '0;
            r_kind      <= KIND_HEADER;
            r_art_count <= '0;
            r_unsup     <= 1'b0;
            r_field     <= '0;
            r_fill      <= '0;
            r_rec       <= '0;
            r_sub       <= '0;
            r_in_frame  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ES_CODE:   r_es_code   <= i_cfg_data;
                    REG_FIRE_CODE: r_fire_code <= i_cfg_data;
                    REG_DET_CODE:  r_det_code  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_offset    <= n_offset;
                r_acc       <= n_acc;
                r_kind      <= n_kind;
                r_art_count <= n_art_count;
                r_unsup     <= n_unsup;
                r_field     <= n_field;
                r_fill      <= n_fill;
                r_rec       <= n_rec;
                r_sub       <= n_sub;
                r_in_frame  <= n_in_frame;
                r_out_valid <= n_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_out <= n_out;
        end
    end

endmodule
